/* design/sea_pkg.sv */
// ----------------------------------------------------------------------------
// Segment extent allocator package
// Sizes, command and status codes, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
package sea_pkg;

    localparam int MAX_ENTRIES      = 64;
    localparam int PAGES_PER_EXTENT = 8;

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ID_W   = 16;
    localparam int EXT_W  = 8;
    localparam int PAGE_W = 32;

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [1:0] CMD_LOOKUP     = 2'd2;

    localparam logic [1:0] ST_NEW       = 2'd0;
    localparam logic [1:0] ST_DONE      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [EXT_W-1:0]  extents;
        logic              used;
        logic [PAGE_W-1:0] page;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG_SCAN,
        S_ID_SCAN,
        S_LATER_SCAN,
        S_WALK,
        S_DONE
    } state_t;

endpackage

/* design/sea_if.sv */
// ----------------------------------------------------------------------------
// Segment extent allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sea_req_if;
    import sea_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       command;
    logic [EXT_W-1:0] extent_count;
    logic [ID_W-1:0]  target_id;

    modport source (output valid, command, extent_count, target_id, input ready);
    modport sink   (input valid, command, extent_count, target_id, output ready);
endinterface

interface sea_rsp_if;
    import sea_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ID_W-1:0]   result_id;
    logic [PAGE_W-1:0] start_page;

    modport source (output valid, status, result_id, start_page, input ready);
    modport sink   (input valid, status, result_id, start_page, output ready);
endinterface

/* design/sea_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
module sea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/segment_extent_allocator.sv */
// ----------------------------------------------------------------------------
// Segment extent allocator
// Table of segments in one RAM, scanned by a read-compare sequencer.
// ----------------------------------------------------------------------------
//
//  channel  role    payload
//  -------  ------  ---------------------------------------------
//  req      sink    command, extent_count, target_id
//  rsp      source  status, result_id, start_page
//
//  One item is worked at a time. A scan reads one table entry per cycle from
//  the RAM port; an unregister of the last used segment adds a backward trim
//  walk over the free entries below it.
//  Reset clears the entry count, highest id and free-page pointer; the RAM
//  needs no clearing, since every scan stops at the entry count.
//  A new item is taken while the previous result waits in the output
//  register; a stalled response only holds the sequencer in its final state.
//
module segment_extent_allocator (
    input  logic             clk,
    input  logic             rst_n,
    sea_req_if.sink          req,
    sea_rsp_if.source        rsp
);
    import sea_pkg::*;

    localparam logic [PAGE_W-1:0] PAGE_MUL  = PAGE_W'(PAGES_PER_EXTENT);
    localparam logic [CNT_W-1:0]  TABLE_MAX = CNT_W'(MAX_ENTRIES);

    // Sequencer control state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [ID_W-1:0]   highest_reg, highest_next;
    logic [PAGE_W-1:0] nfp_reg, nfp_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;

    // Working registers of the current item.
    logic [1:0]        cmd_reg, cmd_next;
    logic [EXT_W-1:0]  ext_reg, ext_next;
    logic [ID_W-1:0]   tid_reg, tid_next;
    logic [CNT_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    entry_t            pos_entry_reg, pos_entry_next;
    logic [IDX_W-1:0]  walk_idx_reg, walk_idx_next;
    logic [PAGE_W-1:0] walk_page_reg, walk_page_next;

    // Result staging and output register.
    logic [1:0]        res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [PAGE_W-1:0] res_page_reg, res_page_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [PAGE_W-1:0] out_page_reg, out_page_next;

    // RAM access.
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wentry;
    logic [IDX_W-1:0]  ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t            rd_entry;

    logic              scan_more;
    logic [ID_W-1:0]   new_id;

    sea_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign scan_more = (addr_reg < total_reg);
    assign new_id    = highest_reg + 1'b1;

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.result_id  = out_id_reg;
    assign rsp.start_page = out_page_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            highest_reg   <= '0;
            nfp_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            highest_reg   <= highest_next;
            nfp_reg       <= nfp_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ext_reg        <= ext_next;
        tid_reg        <= tid_next;
        addr_reg       <= addr_next;
        pend_idx_reg   <= pend_idx_next;
        pos_reg        <= pos_next;
        pos_entry_reg  <= pos_entry_next;
        walk_idx_reg   <= walk_idx_next;
        walk_page_reg  <= walk_page_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_page_reg   <= res_page_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_page_reg   <= out_page_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        highest_next    = highest_reg;
        nfp_next        = nfp_reg;
        pend_next       = 1'b0;
        cmd_next        = cmd_reg;
        ext_next        = ext_reg;
        tid_next        = tid_reg;
        addr_next       = addr_reg;
        pend_idx_next   = pend_idx_reg;
        pos_next        = pos_reg;
        pos_entry_next  = pos_entry_reg;
        walk_idx_next   = walk_idx_reg;
        walk_page_next  = walk_page_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_page_next   = res_page_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_page_next   = out_page_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        ram_we     = 1'b0;
        ram_waddr  = pend_idx_reg;
        ram_wentry = rd_entry;
        ram_raddr  = addr_reg[IDX_W-1:0];

        // The scan states read one entry per cycle; the compare works on the
        // entry read in the previous cycle.
        if (state_reg == S_REG_SCAN || state_reg == S_ID_SCAN
            || state_reg == S_LATER_SCAN)
        begin
            pend_next     = scan_more;
            pend_idx_next = addr_reg[IDX_W-1:0];
            if (scan_more)
            begin
                addr_next = addr_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next  = req.command;
                    ext_next  = req.extent_count;
                    tid_next  = req.target_id;
                    addr_next = '0;
                    if (req.command == CMD_REGISTER)
                    begin
                        state_next = S_REG_SCAN;
                    end
                    else if (req.command == CMD_UNREGISTER || req.command == CMD_LOOKUP)
                    begin
                        state_next = S_ID_SCAN;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_id_next     = req.target_id;
                        res_page_next   = '0;
                        state_next      = S_DONE;
                    end
                end
            end

            S_REG_SCAN:
            begin
                if (pend_reg && !rd_entry.used && rd_entry.extents == ext_reg)
                begin
                    // Reuse the first free entry of the same size.
                    pend_next       = 1'b0;
                    ram_we          = 1'b1;
                    ram_waddr       = pend_idx_reg;
                    ram_wentry      = rd_entry;
                    ram_wentry.used = 1'b1;
                    if (rd_entry.id > highest_reg)
                    begin
                        highest_next = rd_entry.id;
                    end
                    res_status_next = ST_DONE;
                    res_id_next     = rd_entry.id;
                    res_page_next   = rd_entry.page;
                    state_next      = S_DONE;
                end
                else if (!pend_reg && !scan_more)
                begin
                    if (total_reg == TABLE_MAX)
                    begin
                        res_status_next = ST_FULL;
                        res_id_next     = tid_reg;
                        res_page_next   = '0;
                    end
                    else
                    begin
                        // Append a new segment at the free-page pointer.
                        ram_we             = 1'b1;
                        ram_waddr          = total_reg[IDX_W-1:0];
                        ram_wentry.id      = new_id;
                        ram_wentry.extents = ext_reg;
                        ram_wentry.used    = 1'b1;
                        ram_wentry.page    = nfp_reg;
                        total_next         = total_reg + 1'b1;
                        nfp_next           = nfp_reg + PAGE_W'(ext_reg) * PAGE_MUL;
                        if (new_id > highest_reg)
                        begin
                            highest_next = new_id;
                        end
                        res_status_next = ST_NEW;
                        res_id_next     = new_id;
                        res_page_next   = nfp_reg;
                    end
                    state_next = S_DONE;
                end
            end

            S_ID_SCAN:
            begin
                if (pend_reg && rd_entry.id == tid_reg)
                begin
                    pend_next = 1'b0;
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        res_status_next = ST_DONE;
                        res_id_next     = tid_reg;
                        res_page_next   = rd_entry.page;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        pos_next       = pend_idx_reg;
                        pos_entry_next = rd_entry;
                        addr_next      = CNT_W'(pend_idx_reg) + 1'b1;
                        state_next     = S_LATER_SCAN;
                    end
                end
                else if (!pend_reg && !scan_more)
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_id_next     = tid_reg;
                    res_page_next   = '0;
                    state_next      = S_DONE;
                end
            end

            S_LATER_SCAN:
            begin
                res_status_next = ST_DONE;
                res_id_next     = tid_reg;
                res_page_next   = '0;
                if (pend_reg && rd_entry.used)
                begin
                    // A used entry follows, so only mark this one free.
                    pend_next       = 1'b0;
                    ram_we          = 1'b1;
                    ram_waddr       = pos_reg;
                    ram_wentry      = pos_entry_reg;
                    ram_wentry.used = 1'b0;
                    state_next      = S_DONE;
                end
                else if (!pend_reg && !scan_more)
                begin
                    walk_idx_next  = pos_reg;
                    walk_page_next = pos_entry_reg.page;
                    if (pos_reg == '0)
                    begin
                        nfp_next   = pos_entry_reg.page;
                        total_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_raddr     = pos_reg - 1'b1;
                        pend_idx_next = pos_reg - 1'b1;
                        pend_next     = 1'b1;
                        state_next    = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                // Walk back over the free run before the trimmed entry; the
                // read of the next lower entry goes out as soon as one is free.
                if (!rd_entry.used)
                begin
                    walk_idx_next  = pend_idx_reg;
                    walk_page_next = rd_entry.page;
                    if (pend_idx_reg == '0)
                    begin
                        nfp_next   = rd_entry.page;
                        total_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_raddr     = pend_idx_reg - 1'b1;
                        pend_idx_next = pend_idx_reg - 1'b1;
                        pend_next     = 1'b1;
                    end
                end
                else
                begin
                    nfp_next   = walk_page_reg;
                    total_next = CNT_W'(walk_idx_reg);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_page_next   = res_page_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TABLE_MAX)
        else $error("entry count beyond table size");

    a_walk_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> pend_reg)
        else $error("trim walk without a read in flight");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg != S_IDLE && state_reg != S_DONE))
        else $error("table written outside a scan");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && state_reg != S_WALK) |-> (CNT_W'(pend_idx_reg) < total_reg))
        else $error("scan read beyond the entry count");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg != S_IDLE)
        else $error("accepted item not started");
`endif

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Segment extent allocator testbench
// Sends register, unregister and lookup items with random stalls on both
// channels and checks every response against a behavioral segment table.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sea_pkg::*;

    // The package names three commands; the fourth encoding is answered as
    // a miss and must leave the table alone.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Worst case for one item is a full scan plus a full backward walk.
    localparam int DRAIN_CYCLES     = 2 * MAX_ENTRIES + 8;
    localparam int RANDOM_PER_PHASE = 420;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   result_id;
        logic [PAGE_W-1:0] start_page;
    } seg_response_t;

    // ------------------------------------------------------------------------
    // Segment table scoreboard. It keeps its own copy of the table, works out
    // the response of every accepted item and compares the responses in order.
    // ------------------------------------------------------------------------
    class segment_book;
        logic [ID_W-1:0]   seg_id   [MAX_ENTRIES];
        logic [EXT_W-1:0]  seg_ext  [MAX_ENTRIES];
        bit                seg_used [MAX_ENTRIES];
        logic [PAGE_W-1:0] seg_page [MAX_ENTRIES];
        int                seg_count = 0;
        logic [ID_W-1:0]   top_id    = '0;
        logic [PAGE_W-1:0] free_page = '0;
        seg_response_t     pending_responses [$];
        int                errors  = 0;
        int                checked = 0;
        int                deepest = 0;
        int                status_seen [4] = '{0, 0, 0, 0};
        bit                id_wrapped = 1'b0;

        // Lowest-indexed entry with this id, used or free; -1 when absent.
        function int find_id(logic [ID_W-1:0] id);
            for (int i = 0; i < seg_count; i++) begin
                if (seg_id[i] == id)
                    return i;
            end
            return -1;
        endfunction

        function void note_request(logic [1:0] cmd, logic [EXT_W-1:0] ext,
                                   logic [ID_W-1:0] tid);
            seg_response_t     want;
            int                pos;
            bit                hit;
            bit                later;
            logic [ID_W-1:0]   new_id;

            want = '{ST_NOT_FOUND, tid, PAGE_W'(0)};
            case (cmd)
                CMD_REGISTER:
                begin
                    hit = 1'b0;
                    for (int i = 0; i < seg_count && !hit; i++) begin
                        if (!seg_used[i] && seg_ext[i] == ext) begin
                            hit = 1'b1;
                            seg_used[i] = 1'b1;
                            if (seg_id[i] > top_id)
                                top_id = seg_id[i];
                            want = '{ST_DONE, seg_id[i], seg_page[i]};
                        end
                    end
                    if (!hit && seg_count >= MAX_ENTRIES) begin
                        want = '{ST_FULL, tid, PAGE_W'(0)};
                    end
                    else if (!hit) begin
                        new_id = top_id + 1'b1;
                        if (new_id == '0)
                            id_wrapped = 1'b1;
                        seg_id[seg_count]   = new_id;
                        seg_ext[seg_count]  = ext;
                        seg_used[seg_count] = 1'b1;
                        seg_page[seg_count] = free_page;
                        want = '{ST_NEW, new_id, free_page};
                        seg_count++;
                        free_page = free_page + PAGE_W'(PAGES_PER_EXTENT) * PAGE_W'(ext);
                        if (new_id > top_id)
                            top_id = new_id;
                    end
                end
                CMD_UNREGISTER:
                begin
                    pos = find_id(tid);
                    if (pos >= 0) begin
                        later = 1'b0;
                        for (int j = pos + 1; j < seg_count; j++) begin
                            if (seg_used[j])
                                later = 1'b1;
                        end
                        if (later) begin
                            seg_used[pos] = 1'b0;
                        end
                        else begin
                            // Nothing used above: drop the entry and the free
                            // run below it, and give their pages back.
                            while (pos > 0 && !seg_used[pos - 1])
                                pos--;
                            free_page = seg_page[pos];
                            seg_count = pos;
                        end
                        want = '{ST_DONE, tid, PAGE_W'(0)};
                    end
                end
                CMD_LOOKUP:
                begin
                    pos = find_id(tid);
                    if (pos >= 0)
                        want = '{ST_DONE, tid, seg_page[pos]};
                end
                default:
                begin
                end
            endcase
            status_seen[want.status]++;
            if (seg_count > deepest)
                deepest = seg_count;
            pending_responses.push_back(want);
        endfunction

        task report(string what);
            errors++;
            $display("tb: mismatch at response %0d: %s", checked, what);
        endtask

        task check_response(seg_response_t got);
            seg_response_t want;

            checked++;
            if (pending_responses.size() == 0) begin
                report($sformatf("unexpected response status %0d id %0d page 0x%08h",
                                 got.status, got.result_id, got.start_page));
                return;
            end
            want = pending_responses.pop_front();
            if (got.status != want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.result_id != want.result_id)
                report($sformatf("result_id %0d, want %0d", got.result_id, want.result_id));
            if (got.start_page != want.start_page)
                report($sformatf("start_page 0x%08h, want 0x%08h",
                                 got.start_page, want.start_page));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block.
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #4ns clk = ~clk;

    sea_req_if req_ch ();
    sea_rsp_if rsp_ch ();

    segment_extent_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    segment_book book = new;

    // Percent of cycles in which the request side holds back an item and in
    // which the response side refuses one. Changed between phases.
    int req_idle_pct = 0;
    int rsp_idle_pct = 0;

    // The response side draws a fresh ready every cycle, so stalls land on
    // every step of the sequencer, including while a new item is taken.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            rsp_ch.ready <= rst_n && ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // Every accepted response is checked against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            book.check_response('{rsp_ch.status, rsp_ch.result_id, rsp_ch.start_page});
    end

    // ------------------------------------------------------------------------
    // Request side. An item is presented at a rising edge, possibly after a
    // few idle cycles, and held until the edge at which ready is seen high.
    // valid stays high from one item to the next when no idle cycle falls in
    // between, so it gets only one assignment per edge.
    // ------------------------------------------------------------------------
    task automatic send_item(logic [1:0] cmd, logic [EXT_W-1:0] ext, logic [ID_W-1:0] tid);
        while ($urandom_range(99) < req_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.extent_count <= ext;
        req_ch.target_id    <= tid;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        book.note_request(cmd, ext, tid);
    endtask

    // Mostly well-formed traffic: ids taken from the live table so that
    // unregister and lookup hit, extents drawn from a narrow set or from
    // existing entries so that freed entries get reused. The rest is noise:
    // ids that were never handed out, any extent, and the unused command.
    task automatic send_random_item();
        int               roll;
        logic [1:0]       cmd;
        logic [EXT_W-1:0] ext;
        logic [ID_W-1:0]  tid;

        roll = $urandom_range(99);
        if (roll < 42)
            cmd = CMD_REGISTER;
        else if (roll < 75)
            cmd = CMD_UNREGISTER;
        else if (roll < 95)
            cmd = CMD_LOOKUP;
        else
            cmd = CMD_UNUSED;

        ext  = EXT_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 40)
            ext = EXT_W'($urandom_range(7));
        else if (roll < 60 && book.seg_count > 0)
            ext = book.seg_ext[$urandom_range(book.seg_count - 1)];
        else if (roll < 65)
            ext = '0;
        else if (roll < 70)
            ext = '1;

        tid  = ID_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 70 && book.seg_count > 0)
            tid = book.seg_id[$urandom_range(book.seg_count - 1)];
        else if (roll < 80)
            tid = book.top_id + 1'b1;

        send_item(cmd, ext, tid);
    endtask

    // One phase: grow the table until it is full, push a few registers
    // against the full table, then run random traffic that drains and
    // refills it.
    task automatic run_phase(int req_pct, int rsp_pct);
        req_idle_pct = req_pct;
        rsp_idle_pct = rsp_pct;
        while (book.seg_count < MAX_ENTRIES)
            send_item(CMD_REGISTER, EXT_W'($urandom), ID_W'($urandom));
        repeat (3)
            send_item(CMD_REGISTER, EXT_W'($urandom), ID_W'($urandom));
        repeat (RANDOM_PER_PHASE)
            send_random_item();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_REGISTER;
        req_ch.extent_count = '0;
        req_ch.target_id    = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        req_idle_pct = 21;
        rsp_idle_pct = 55;

        // Requests against the empty table: every command misses, and the
        // unused command is answered as a miss.
        send_item(CMD_LOOKUP, '0, '0);
        send_item(CMD_UNREGISTER, '0, 16'd5);
        send_item(CMD_UNUSED, '1, '1);

        // Appends with the extreme sizes. A zero-extent segment takes no
        // pages, so the next one starts on the same page.
        send_item(CMD_REGISTER, '0, '1);
        send_item(CMD_REGISTER, '1, '1);
        send_item(CMD_REGISTER, 8'd1, '0);
        send_item(CMD_LOOKUP, '0, 16'd2);
        send_item(CMD_LOOKUP, '0, '1);

        // Freeing a middle entry keeps it in place; a register of the same
        // size takes it back with its old id and page.
        send_item(CMD_UNREGISTER, '0, 16'd2);
        send_item(CMD_REGISTER, '1, '0);

        // Free the first entry, then the last: only the last is trimmed.
        // Freeing the remaining one then trims down to entry zero and the
        // table is empty again.
        send_item(CMD_UNREGISTER, '0, 16'd1);
        send_item(CMD_UNREGISTER, '0, 16'd3);
        send_item(CMD_UNREGISTER, '0, 16'd2);
        send_item(CMD_LOOKUP, '0, 16'd1);

        // A freed entry still answers lookups and unregisters by id.
        send_item(CMD_REGISTER, 8'd4, '0);
        send_item(CMD_REGISTER, 8'd4, '0);
        send_item(CMD_UNREGISTER, '0, 16'd4);
        send_item(CMD_LOOKUP, '0, 16'd4);
        send_item(CMD_UNREGISTER, '0, 16'd4);
        send_item(CMD_REGISTER, 8'd4, '0);
        send_item(CMD_UNUSED, 8'd3, '0);

        run_phase(21, 55);
        run_phase(55, 21);
        run_phase(0, 0);

        // A short random tail against whatever the phases left behind.
        repeat (40)
            send_random_item();

        req_ch.valid <= 1'b0;

        while (book.pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("tb: %0d responses checked: %0d appended, %0d reused or done, %0d missed, %0d full",
                 book.checked, book.status_seen[ST_NEW], book.status_seen[ST_DONE],
                 book.status_seen[ST_NOT_FOUND], book.status_seen[ST_FULL]);
        $display("tb: table reached %0d entries, id counter wrapped: %0d",
                 book.deepest, book.id_wrapped);
        if (book.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #100ms;
        $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
design/sea_pkg.sv
design/sea_if.sv
design/sea_ram.sv
design/segment_extent_allocator.sv
dv/tb.sv
